@@ rtl/core/b64d_pkg.sv @@
package b64d_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } t_b64d_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       out_end;
    } t_b64d_out;

    // classified character as it sits between front and back
    typedef struct packed {
        logic [5:0] sextet;
        logic       is_pad;
        logic       last;
    } t_b64d_sym;

    // standard alphabet; '=', NUL and anything else map to zero
    function automatic logic [5:0] sextet_of(input logic [7:0] c);
        logic [5:0] v;
        v = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            v = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            v = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            v = 6'd62;
        end else if (c == 8'h2F) begin
            v = 6'd63;
        end
        return v;
    endfunction

endpackage

@@ rtl/core/b64d_queue.sv @@
module b64d_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             wr_en, rd_en;

    assign o_full    = (r_count == FULL_CNT);
    assign o_empty   = (r_count == '0);
    assign wr_en     = i_wr && !o_full;
    assign rd_en     = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

@@ rtl/core/b64d_front.sv @@
module b64d_front (
    input  b64d_pkg::t_b64d_in  i_item,
    output b64d_pkg::t_b64d_sym o_sym
);
    import b64d_pkg::*;

    always_comb begin
        o_sym.sextet = sextet_of(i_item.in_char);
        o_sym.is_pad = (i_item.in_char == PAD_CHAR);
        o_sym.last   = i_item.in_last;
    end

endmodule

@@ rtl/core/b64d_back.sv @@
module b64d_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_sym_empty,
    input  b64d_pkg::t_b64d_sym i_sym,
    output logic                o_sym_rd,
    input  logic                i_res_full,
    output logic                o_res_wr,
    output b64d_pkg::t_b64d_out o_res
);
    import b64d_pkg::*;

    logic [1:0] r_pos,  n_pos;
    logic [5:0] r_prev, n_prev;
    logic [7:0] byte_raw;
    logic       byte_ok;
    logic       take;

    assign take     = !i_sym_empty && !i_res_full;
    assign o_sym_rd = take;
    assign o_res_wr = take && (byte_ok || i_sym.last);

    always_comb begin
        unique case (r_pos)
            2'd0: begin
                // final char on a group boundary stands for implicit padding
                byte_raw = {i_sym.sextet, 2'b00};
                byte_ok  = i_sym.last;
            end
            2'd1: begin
                byte_raw = {r_prev, i_sym.sextet[5:4]};
                byte_ok  = 1'b1;
            end
            2'd2: begin
                byte_raw = {r_prev[3:0], i_sym.sextet[5:2]};
                byte_ok  = !i_sym.is_pad;
            end
            default: begin
                byte_raw = {r_prev[1:0], i_sym.sextet};
                byte_ok  = !i_sym.is_pad;
            end
        endcase

        o_res.out_byte   = byte_ok ? byte_raw : 8'd0;
        o_res.byte_valid = byte_ok;
        o_res.out_end    = i_sym.last;

        n_pos  = r_pos;
        n_prev = r_prev;
        if (take) begin
            if (i_sym.last) begin
                n_pos  = 2'd0;
                n_prev = 6'd0;
            end else begin
                n_pos  = r_pos + 2'd1;
                n_prev = i_sym.sextet;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= 2'd0;
            r_prev <= 6'd0;
        end else begin
            r_pos  <= n_pos;
            r_prev <= n_prev;
        end
    end

endmodule

@@ rtl/core/base64_stream_decoder_core.sv @@
// Flow: a request accepted into the symbol queue is taken by the back end once
// the result queue has room; its result then sits on the output ports.
// Throughput: one character per cycle; the back end retires a symbol every cycle
// it is not stalled, and each side stalls on its own through the two queues.
// Reset: synchronous, active low; empties both queues and clears the group
// position and previous sextet.
module base64_stream_decoder_core #(
    parameter int unsigned QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  b64d_pkg::t_b64d_in  i_in_item,
    output logic                empty,
    input  logic                pop,
    output b64d_pkg::t_b64d_out o_out_item
);
    import b64d_pkg::*;

    t_b64d_sym front_sym;
    t_b64d_sym back_sym;
    t_b64d_out back_res;
    logic      sym_empty;
    logic      sym_rd;
    logic      res_full;
    logic      res_wr;

    b64d_front u_front (
        .i_item (i_in_item),
        .o_sym  (front_sym)
    );

    b64d_queue #(
        .WIDTH ($bits(t_b64d_sym)),
        .DEPTH (QUEUE_DEPTH)
    ) u_sym_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (push),
        .i_wr_data (front_sym),
        .o_full    (full),
        .i_rd      (sym_rd),
        .o_rd_data (back_sym),
        .o_empty   (sym_empty)
    );

    b64d_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sym_empty (sym_empty),
        .i_sym       (back_sym),
        .o_sym_rd    (sym_rd),
        .i_res_full  (res_full),
        .o_res_wr    (res_wr),
        .o_res       (back_res)
    );

    b64d_queue #(
        .WIDTH ($bits(t_b64d_out)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (res_wr),
        .i_wr_data (back_res),
        .o_full    (res_full),
        .i_rd      (pop),
        .o_rd_data (o_out_item),
        .o_empty   (empty)
    );

endmodule

@@ sim/tb.sv @@
module tb;
    import b64d_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_CYCLES = 300;

    // tracks the group position and previous sextet, queues the expected results
    class decode_scoreboard;
        t_b64d_out   pending[$];
        logic [1:0]  position;
        logic [5:0]  prev_sextet;
        int unsigned mismatches;

        function new();
            position    = 2'd0;
            prev_sextet = 6'd0;
            mismatches  = 0;
        endfunction

        static function logic [5:0] char_value(logic [7:0] c);
            logic [5:0] v;
            v = 6'd0;
            if (c >= "A" && c <= "Z") begin
                v = 6'(c - "A");
            end else if (c >= "a" && c <= "z") begin
                v = 6'(c - "a") + 6'd26;
            end else if (c >= "0" && c <= "9") begin
                v = 6'(c - "0") + 6'd52;
            end else if (c == "+") begin
                v = 6'd62;
            end else if (c == "/") begin
                v = 6'd63;
            end
            return v;
        endfunction

        function void note_char(t_b64d_in req);
            logic [5:0] v;
            logic       is_pad;
            logic [7:0] data;
            logic       valid;
            t_b64d_out  res;
            v      = char_value(req.in_char);
            is_pad = (req.in_char == PAD_CHAR);
            data   = 8'd0;
            valid  = 1'b0;
            case (position)
                2'd0: begin
                    // a lone final character stands for its padded group
                    valid = req.in_last;
                    data  = {v, 2'b00};
                end
                2'd1: begin
                    valid = 1'b1;
                    data  = {prev_sextet, v[5:4]};
                end
                2'd2: begin
                    valid = !is_pad;
                    data  = {prev_sextet[3:0], v[5:2]};
                end
                default: begin
                    valid = !is_pad;
                    data  = {prev_sextet[1:0], v};
                end
            endcase
            if (req.in_last) begin
                position    = 2'd0;
                prev_sextet = 6'd0;
            end else begin
                position    = position + 2'd1;
                prev_sextet = v;
            end
            if (valid || req.in_last) begin
                res.out_byte   = valid ? data : 8'd0;
                res.byte_valid = valid;
                res.out_end    = req.in_last;
                pending = {pending, res};
            end
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            mismatches++;
        endtask

        task check_result(t_b64d_out got);
            t_b64d_out want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result %h", got));
            end else begin
                want = pending.pop_front();
                if (got.out_byte !== want.out_byte)
                    report($sformatf("out_byte got %h want %h", got.out_byte, want.out_byte));
                if (got.byte_valid !== want.byte_valid)
                    report($sformatf("byte_valid got %b want %b",
                                     got.byte_valid, want.byte_valid));
                if (got.out_end !== want.out_end)
                    report($sformatf("out_end got %b want %b", got.out_end, want.out_end));
            end
        endtask
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    logic      pop = 1'b0;
    logic      full;
    logic      empty;
    t_b64d_in  in_item = '0;
    t_b64d_out out_item;

    decode_scoreboard sb = new();

    int unsigned cycle_count = 0;
    int unsigned items_sent = 0;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;

    base64_stream_decoder_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (out_item)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("base64_stream_decoder_core regression: fail");
            $finish;
        end
    end

    // result side: check, then pick pop for the next edge
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            sb.check_result(out_item);
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic logic [7:0] alphabet_char(int unsigned idx);
        if (idx < 26) return 8'("A" + idx);
        if (idx < 52) return 8'("a" + idx - 26);
        if (idx < 62) return 8'("0" + idx - 52);
        return (idx == 62) ? 8'("+") : 8'("/");
    endfunction

    task automatic send_char(input logic [7:0] c, input logic last);
        push    <= 1'b1;
        in_item <= {c, last};
        do @(posedge i_clk); while (full);
        sb.note_char(in_item);
        items_sent++;
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_text(input string s, input bit end_flag);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], end_flag && (i == s.len() - 1));
    endtask

    task automatic send_random_string();
        int unsigned kind;
        int unsigned groups;
        int unsigned tail;
        int unsigned n;
        logic [7:0]  chars[$];
        kind = $urandom_range(99);
        if (kind < 75) begin
            // well formed: whole groups, then an optional padded or bare tail
            groups = $urandom_range(4);
            tail   = $urandom_range(4);
            if (groups == 0 && tail == 0)
                tail = 1;
            repeat (4 * groups) chars = {chars, alphabet_char($urandom_range(63))};
            case (tail)
                1: begin
                    repeat (2) chars = {chars, alphabet_char($urandom_range(63))};
                    repeat (2) chars = {chars, PAD_CHAR};
                end
                2: begin
                    repeat (3) chars = {chars, alphabet_char($urandom_range(63))};
                    chars = {chars, PAD_CHAR};
                end
                3: repeat (2) chars = {chars, alphabet_char($urandom_range(63))};
                4: repeat (3) chars = {chars, alphabet_char($urandom_range(63))};
                default: ;
            endcase
        end else if (kind < 90) begin
            n = $urandom_range(1, 12);
            repeat (n)
                chars = {chars, (($urandom_range(3) == 0) ? PAD_CHAR
                                                          : 8'($urandom_range(255)))};
        end else begin
            // alphabet with stray padding anywhere
            n = $urandom_range(1, 10);
            repeat (n)
                chars = {chars, (($urandom_range(4) == 0) ? PAD_CHAR
                                                          : alphabet_char($urandom_range(63)))};
        end
        foreach (chars[i])
            send_char(chars[i], i == chars.size() - 1);
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_phase(input int unsigned tx_pct, input int unsigned rx_pct,
                             input int unsigned target, input bit with_hold);
        int unsigned start;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        start       = items_sent;
        while (items_sent - start < target) begin
            if (with_hold && hold_requests == 0 && items_sent - start >= target / 2)
                hold_requests++;
            send_random_string();
        end
        drain();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_text("TWFu", 1'b1);
        send_text("TWE=", 1'b1);
        send_text("TQ==", 1'b1);
        // padding then data, then a final character opening a new group
        send_text("AB=C", 1'b0);
        send_text("Q", 1'b1);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char("/", 1'b0);
        send_char("+", 1'b1);
        send_text("z9", 1'b1);
        drain();

        run_phase(30, 67, 300, 1'b1);
        run_phase(67, 30, 300, 1'b0);
        run_phase(0, 0, 300, 1'b0);

        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("base64_stream_decoder_core regression: pass");
        end else begin
            $display("base64_stream_decoder_core regression: fail");
        end
        $finish;
    end

endmodule
